/* src/ptss_pkg.sv */
// ----------------------------------------------------------------------------
// ptss_pkg: shared types, constants and microcode for the slot scheduler
// Holds the slot table sizing, the control word layout, the microprogram ROM
// and small helper functions used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ptss_pkg;

  localparam int unsigned SLOTS    = 4;
  localparam int unsigned SlotW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW     = $clog2(SLOTS + 1);
  localparam int unsigned KindW    = 2;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned ArgW     = 16;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned FreeW    = 3;
  localparam int unsigned TickW    = 32;
  localparam int unsigned DivBits  = 4;
  localparam int unsigned DivSteps = TickW / DivBits;
  localparam int unsigned DivCntW  = (DivSteps > 1) ? $clog2(DivSteps) : 1;
  localparam int unsigned UpcW     = 4;

  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [SLOTS-1:0]   mask_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [HandleW-1:0] handle_t;
  typedef logic [PeriodW-1:0] interval_t;
  typedef logic [ArgW-1:0]    arg_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [FreeW-1:0]   free_t;
  typedef logic [TickW-1:0]   tick_t;
  typedef logic [DivCntW-1:0] divcnt_t;
  typedef logic [UpcW-1:0]    upc_t;

  typedef enum logic [KindW-1:0] {
    KIND_TICK = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_WAIT      = 4'd0,
    OP_TICK_INIT = 4'd1,
    OP_DIV_LOAD  = 4'd2,
    OP_DIV_STEP  = 4'd3,
    OP_RECORD    = 4'd4,
    OP_SEEK      = 4'd5,
    OP_EMIT_TICK = 4'd6,
    OP_ADD       = 4'd7,
    OP_DEL       = 4'd8,
    OP_NOP       = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    J_NEXT       = 3'd0,
    J_DISPATCH   = 3'd1,
    J_DIV_BUSY   = 3'd2,
    J_MORE_SLOTS = 3'd3,
    J_EMIT_DONE  = 3'd4,
    J_GOTO       = 3'd5
  } jcond_e;

  typedef struct packed {
    op_e    op;
    jcond_e jcond;
    upc_t   target;
  } uword_t;

  typedef struct packed {
    logic  in_acc;
    kind_e kind;
    logic  div_busy;
    logic  more_slots;
    logic  emit_done;
  } status_t;

  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_TICK     = 4'd1;
  localparam upc_t UPC_DIV_LOAD = 4'd2;
  localparam upc_t UPC_DIV_STEP = 4'd3;
  localparam upc_t UPC_RECORD   = 4'd4;
  localparam upc_t UPC_SEEK     = 4'd5;
  localparam upc_t UPC_EMIT     = 4'd6;
  localparam upc_t UPC_ADD      = 4'd7;
  localparam upc_t UPC_DEL      = 4'd8;
  localparam upc_t UPC_NOP      = 4'd9;

  // Microprogram. A step either falls through, jumps to its target when its
  // condition holds, or (dispatch and emit steps) holds until it completes.
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '{op: OP_WAIT, jcond: J_GOTO, target: UPC_IDLE};
    unique case (pc)
      UPC_IDLE:     w = '{op: OP_WAIT,      jcond: J_DISPATCH,   target: UPC_IDLE};
      UPC_TICK:     w = '{op: OP_TICK_INIT, jcond: J_NEXT,       target: UPC_IDLE};
      UPC_DIV_LOAD: w = '{op: OP_DIV_LOAD,  jcond: J_NEXT,       target: UPC_IDLE};
      UPC_DIV_STEP: w = '{op: OP_DIV_STEP,  jcond: J_DIV_BUSY,   target: UPC_DIV_STEP};
      UPC_RECORD:   w = '{op: OP_RECORD,    jcond: J_MORE_SLOTS, target: UPC_DIV_LOAD};
      UPC_SEEK:     w = '{op: OP_SEEK,      jcond: J_NEXT,       target: UPC_IDLE};
      UPC_EMIT:     w = '{op: OP_EMIT_TICK, jcond: J_EMIT_DONE,  target: UPC_IDLE};
      UPC_ADD:      w = '{op: OP_ADD,       jcond: J_EMIT_DONE,  target: UPC_IDLE};
      UPC_DEL:      w = '{op: OP_DEL,       jcond: J_EMIT_DONE,  target: UPC_IDLE};
      UPC_NOP:      w = '{op: OP_NOP,       jcond: J_EMIT_DONE,  target: UPC_IDLE};
      default:      w = '{op: OP_WAIT,      jcond: J_GOTO,       target: UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(kind_e k);
    upc_t pc;
    pc = UPC_NOP;
    unique case (k)
      KIND_TICK: pc = UPC_TICK;
      KIND_ADD:  pc = UPC_ADD;
      KIND_DEL:  pc = UPC_DEL;
      KIND_NONE: pc = UPC_NOP;
      default:   pc = UPC_NOP;
    endcase
    return pc;
  endfunction

  // Index of the lowest set bit, zero when the mask is empty.
  function automatic slot_t lowest_set(mask_t m);
    slot_t r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = slot_t'(i);
    end
    return r;
  endfunction

endpackage

/* src/ptss_if.sv */
// ----------------------------------------------------------------------------
// ptss_if: request and result channels of the slot scheduler
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface ptss_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [15:0]            task_handle;
  logic [15:0]            period;
  logic [15:0]            task_argument;

  modport source (output valid, kind, task_handle, period, task_argument, input ready);
  modport sink   (input valid, kind, task_handle, period, task_argument, output ready);
endinterface

interface ptss_out_if;
  logic                   valid;
  logic                   ready;
  logic                   fire;
  logic [15:0]            fired_handle;
  logic [15:0]            fired_argument;
  logic [2:0]             slot_index;
  logic [2:0]             free_slots;
  logic                   last;

  modport source (output valid, fire, fired_handle, fired_argument, slot_index, free_slots,
                  last, input ready);
  modport sink   (input valid, fire, fired_handle, fired_argument, slot_index, free_slots,
                  last, output ready);
endinterface

/* src/ptss_seq.sv */
// ----------------------------------------------------------------------------
// ptss_seq: microprogram sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module ptss_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptss_pkg::status_t st_i,
  output ptss_pkg::uword_t  uw_o
);

  ptss_pkg::upc_t   pc_q, pc_d;
  ptss_pkg::uword_t uw;

  assign uw   = ptss_pkg::ucode_rom(pc_q);
  assign uw_o = uw;

  always_comb begin
    unique case (uw.jcond)
      ptss_pkg::J_NEXT:       pc_d = pc_q + ptss_pkg::upc_t'(1);
      ptss_pkg::J_DISPATCH:   pc_d = st_i.in_acc ? ptss_pkg::dispatch(st_i.kind) : pc_q;
      ptss_pkg::J_DIV_BUSY:   pc_d = st_i.div_busy ? uw.target : pc_q + ptss_pkg::upc_t'(1);
      ptss_pkg::J_MORE_SLOTS: pc_d = st_i.more_slots ? uw.target : pc_q + ptss_pkg::upc_t'(1);
      ptss_pkg::J_EMIT_DONE:  pc_d = st_i.emit_done ? uw.target : pc_q;
      ptss_pkg::J_GOTO:       pc_d = uw.target;
      default:                pc_d = ptss_pkg::UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ptss_pkg::UPC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* src/ptss_mod_unit.sv */
// ----------------------------------------------------------------------------
// ptss_mod_unit: iterative remainder unit
// Restoring division of the tick count by a slot period, DivBits quotient bits
// per cycle; only the remainder is kept and reported as zero or not.
// ----------------------------------------------------------------------------
module ptss_mod_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ptss_pkg::tick_t     dividend_i,
  input  ptss_pkg::interval_t divisor_i,
  output logic                busy_o,
  output logic                rem_zero_o
);

  ptss_pkg::tick_t     dvd_q, dvd_d;
  ptss_pkg::interval_t rem_q, rem_d;
  ptss_pkg::interval_t dvs_q;
  ptss_pkg::divcnt_t   cnt_q;
  logic                busy_q;

  always_comb begin
    logic [ptss_pkg::PeriodW:0] t;
    rem_d = rem_q;
    dvd_d = dvd_q;
    t     = '0;
    for (int k = 0; k < ptss_pkg::DivBits; k++) begin
      t     = {rem_d, dvd_d[ptss_pkg::TickW-1]};
      dvd_d = {dvd_d[ptss_pkg::TickW-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) t = t - {1'b0, dvs_q};
      rem_d = t[ptss_pkg::PeriodW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + ptss_pkg::divcnt_t'(1);
      if (cnt_q == ptss_pkg::divcnt_t'(ptss_pkg::DivSteps - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

/* src/ptss_dpath.sv */
// ----------------------------------------------------------------------------
// ptss_dpath: slot table, tick counter and result register
// Carries out the operation named by the current control word and reports
// the status bits on which the sequencer jumps.
// ----------------------------------------------------------------------------
module ptss_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptss_pkg::uword_t    uw_i,
  output ptss_pkg::status_t   st_o,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_kind_i,
  input  ptss_pkg::handle_t   in_handle_i,
  input  ptss_pkg::interval_t in_period_i,
  input  ptss_pkg::arg_t      in_arg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_fire_o,
  output ptss_pkg::handle_t   out_handle_o,
  output ptss_pkg::arg_t      out_arg_o,
  output ptss_pkg::idx_t      out_idx_o,
  output ptss_pkg::free_t     out_free_o,
  output logic                out_last_o,
  output logic                div_start_o,
  output ptss_pkg::tick_t     div_dividend_o,
  output ptss_pkg::interval_t div_divisor_o,
  input  logic                div_busy_i,
  input  logic                div_zero_i
);

  ptss_pkg::tick_t                            tick_q, tick_d;
  ptss_pkg::handle_t   [ptss_pkg::SLOTS-1:0]  hdl_q, hdl_d;
  ptss_pkg::interval_t [ptss_pkg::SLOTS-1:0]  per_q, per_d;
  ptss_pkg::arg_t      [ptss_pkg::SLOTS-1:0]  arg_q;
  ptss_pkg::cnt_t                             used_q, used_d;
  ptss_pkg::mask_t                            mask_q, mask_d, rest;
  ptss_pkg::slot_t                            ptr_q, ptr_d;
  ptss_pkg::handle_t                          req_hdl_q;
  ptss_pkg::interval_t                        req_per_q;
  ptss_pkg::arg_t                             req_arg_q;

  logic              in_ready, in_acc, out_free, more_slots;
  logic              free_found, match_found;
  ptss_pkg::slot_t   free_idx, match_idx;
  logic              arg_we;
  ptss_pkg::slot_t   arg_widx;

  logic              ov_q;
  logic              emit, e_fire, e_last;
  ptss_pkg::handle_t e_hdl;
  ptss_pkg::arg_t    e_arg;
  ptss_pkg::idx_t    e_idx;
  logic              emit_done;

  logic              o_fire_q, o_last_q;
  ptss_pkg::handle_t o_hdl_q;
  ptss_pkg::arg_t    o_arg_q;
  ptss_pkg::idx_t    o_idx_q;
  ptss_pkg::free_t   o_free_q;

  assign in_ready   = (uw_i.op == ptss_pkg::OP_WAIT);
  assign in_acc     = in_valid_i && in_ready;
  assign out_free   = !ov_q || out_ready_i;
  assign more_slots = (ptr_q != ptss_pkg::slot_t'(ptss_pkg::SLOTS - 1));
  assign rest       = mask_q & ~(ptss_pkg::mask_t'(1) << ptr_q);

  // First empty slot for an add and first matching slot for a delete.
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = ptss_pkg::SLOTS - 1; i >= 0; i--) begin
      if (hdl_q[i] == '0) begin
        free_found = 1'b1;
        free_idx   = ptss_pkg::slot_t'(i);
      end
      if (hdl_q[i] == req_hdl_q) begin
        match_found = 1'b1;
        match_idx   = ptss_pkg::slot_t'(i);
      end
    end
  end

  always_comb begin
    tick_d    = tick_q;
    hdl_d     = hdl_q;
    per_d     = per_q;
    used_d    = used_q;
    mask_d    = mask_q;
    ptr_d     = ptr_q;
    arg_we    = 1'b0;
    arg_widx  = free_idx;
    emit      = 1'b0;
    e_fire    = 1'b0;
    e_hdl     = '0;
    e_arg     = '0;
    e_idx     = ptss_pkg::idx_t'(ptss_pkg::SLOTS);
    e_last    = 1'b1;
    emit_done = out_free;
    unique case (uw_i.op)
      ptss_pkg::OP_WAIT: begin
      end
      ptss_pkg::OP_TICK_INIT: begin
        tick_d = tick_q + ptss_pkg::tick_t'(1);
        ptr_d  = '0;
        mask_d = '0;
      end
      ptss_pkg::OP_DIV_LOAD: begin
      end
      ptss_pkg::OP_DIV_STEP: begin
      end
      ptss_pkg::OP_RECORD: begin
        mask_d[ptr_q] = (hdl_q[ptr_q] != '0) && (per_q[ptr_q] != '0) && div_zero_i;
        if (more_slots) ptr_d = ptr_q + ptss_pkg::slot_t'(1);
      end
      ptss_pkg::OP_SEEK: begin
        ptr_d = ptss_pkg::lowest_set(mask_q);
      end
      ptss_pkg::OP_EMIT_TICK: begin
        emit      = out_free;
        emit_done = out_free && ((mask_q == '0) || (rest == '0));
        if (mask_q != '0) begin
          e_fire = 1'b1;
          e_hdl  = hdl_q[ptr_q];
          e_arg  = arg_q[ptr_q];
          e_last = (rest == '0);
          if (out_free) begin
            mask_d = rest;
            ptr_d  = ptss_pkg::lowest_set(rest);
          end
        end
      end
      ptss_pkg::OP_ADD: begin
        emit = out_free;
        if (req_hdl_q != '0) begin
          e_fire = 1'b1;
          e_hdl  = req_hdl_q;
          e_arg  = req_arg_q;
          if (free_found) begin
            e_idx = ptss_pkg::idx_t'(free_idx);
            if (out_free) begin
              hdl_d[free_idx] = req_hdl_q;
              per_d[free_idx] = req_per_q;
              arg_we          = 1'b1;
              used_d          = used_q + ptss_pkg::cnt_t'(1);
            end
          end
        end
      end
      ptss_pkg::OP_DEL: begin
        emit = out_free;
        if ((req_hdl_q != '0) && match_found) begin
          e_idx = ptss_pkg::idx_t'(match_idx);
          if (out_free) begin
            hdl_d[match_idx] = '0;
            per_d[match_idx] = '0;
            used_d           = used_q - ptss_pkg::cnt_t'(1);
          end
        end
      end
      ptss_pkg::OP_NOP: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      hdl_q  <= '0;
      per_q  <= '0;
      used_q <= '0;
      mask_q <= '0;
      ptr_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      tick_q <= tick_d;
      hdl_q  <= hdl_d;
      per_q  <= per_d;
      used_q <= used_d;
      mask_q <= mask_d;
      ptr_q  <= ptr_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_hdl_q <= in_handle_i;
      req_per_q <= in_period_i;
      req_arg_q <= in_arg_i;
    end
    if (arg_we) arg_q[arg_widx] <= req_arg_q;
    if (emit) begin
      o_fire_q <= e_fire;
      o_hdl_q  <= e_hdl;
      o_arg_q  <= e_arg;
      o_idx_q  <= e_idx;
      o_free_q <= ptss_pkg::free_t'(ptss_pkg::SLOTS) - ptss_pkg::free_t'(used_d);
      o_last_q <= e_last;
    end
  end

  assign st_o = '{in_acc:     in_acc,
                  kind:       ptss_pkg::kind_e'(in_kind_i),
                  div_busy:   div_busy_i,
                  more_slots: more_slots,
                  emit_done:  emit_done};

  assign in_ready_o     = in_ready;
  assign out_valid_o    = ov_q;
  assign out_fire_o     = o_fire_q;
  assign out_handle_o   = o_hdl_q;
  assign out_arg_o      = o_arg_q;
  assign out_idx_o      = o_idx_q;
  assign out_free_o     = o_free_q;
  assign out_last_o     = o_last_q;
  assign div_start_o    = (uw_i.op == ptss_pkg::OP_DIV_LOAD);
  assign div_dividend_o = tick_q;
  assign div_divisor_o  = per_q[ptr_q];

endmodule

/* src/periodic_task_slot_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler: four-slot periodic task table
// Top level joining the microprogram sequencer, datapath and remainder unit.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req_i (tick, add task, delete task) and results
// leave on res_o, both valid/ready channels; a transaction completes when
// valid and ready are high together. Each request yields one or more results;
// the final one carries last. A tick yields one result per firing slot in
// slot order, or a single non-firing result when none fires.
// An add, delete or unused request is handled by its own sequencer step after
// acceptance, which writes its result into the output register. A tick first
// advances the count, then for each slot loads the shared remainder unit, waits
// while the unit retires four dividend bits per cycle, and records whether the
// slot fires; then come a seek step and the emit step, which writes the first
// result. Further results follow one per cycle while the receiver takes them.
// Throughput is one request at a time; req_i.ready is high only while the
// sequencer waits for a new request, and it may be high while the last
// result of the previous request still sits in the output register.
// Reset (rst_ni low, asynchronous) empties all slots, clears the tick count
// and drops res_o.valid. If the receiver stalls, the held result stays
// unchanged and the sequencer waits at its emit step until it is taken.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptss_in_if.sink    req_i,
  ptss_out_if.source res_o
);

  ptss_pkg::uword_t    uw;
  ptss_pkg::status_t   st;
  logic                div_start, div_busy, div_zero;
  ptss_pkg::tick_t     div_dividend;
  ptss_pkg::interval_t div_divisor;

  ptss_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .st_i  (st),
    .uw_o  (uw)
  );

  ptss_mod_unit u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .rem_zero_o(div_zero)
  );

  ptss_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uw_i          (uw),
    .st_o          (st),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (req_i.ready),
    .in_kind_i     (req_i.kind),
    .in_handle_i   (req_i.task_handle),
    .in_period_i   (req_i.period),
    .in_arg_i      (req_i.task_argument),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .out_fire_o    (res_o.fire),
    .out_handle_o  (res_o.fired_handle),
    .out_arg_o     (res_o.fired_argument),
    .out_idx_o     (res_o.slot_index),
    .out_free_o    (res_o.free_slots),
    .out_last_o    (res_o.last),
    .div_start_o   (div_start),
    .div_dividend_o(div_dividend),
    .div_divisor_o (div_divisor),
    .div_busy_i    (div_busy),
    .div_zero_i    (div_zero)
  );

endmodule

/* src/ptss_checker.sv */
// ----------------------------------------------------------------------------
// ptss_checker: port-level assertions for the slot scheduler
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ptss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_fire_i,
  input logic [2:0]  out_idx_i,
  input logic        out_last_i
);

  // A held result must not be withdrawn before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // After a request transaction, no new request is taken in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted twice in successive cycles");

  // While a tick still has results to deliver no new request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("request accepted in the middle of a tick burst");

  // Only ticks produce more than one result, and those always fire.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_fire_i && (out_idx_i == 3'(ptss_pkg::SLOTS)))
    else $error("non-final result that is not a tick firing");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (req_i.valid),
  .in_ready_i (req_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_fire_i (res_o.fire),
  .out_idx_i  (res_o.slot_index),
  .out_last_i (res_o.last)
);

/* bench/slot_fire_checker.sv */
// ----------------------------------------------------------------------------
// slot_fire_checker: result predictor and comparator for the slot scheduler
// Watches both channels. It keeps its own copy of the slot table and the tick
// counter, and predicts the result transactions for every request. It then
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_fire_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptss_in_if          req_i,
  ptss_out_if         res_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic              fire;
    ptss_pkg::handle_t handle;
    ptss_pkg::arg_t    argument;
    ptss_pkg::idx_t    slot;
    ptss_pkg::free_t   free_n;
    logic              last;
  } fire_report_t;

  fire_report_t due_results[$];

  ptss_pkg::tick_t     tick_count;
  ptss_pkg::handle_t   slot_handle [ptss_pkg::SLOTS];
  ptss_pkg::interval_t slot_period [ptss_pkg::SLOTS];
  ptss_pkg::arg_t      slot_arg    [ptss_pkg::SLOTS];
  ptss_pkg::cnt_t      used_slots;
  int unsigned         errors = 0;

  assign fail_count_o = errors;

  // The free count is taken from the table as it stands after the update.
  function automatic fire_report_t make_report(logic fire, ptss_pkg::handle_t h,
                                               ptss_pkg::arg_t a, ptss_pkg::idx_t slot,
                                               logic last);
    fire_report_t r;
    r.fire     = fire;
    r.handle   = h;
    r.argument = a;
    r.slot     = slot;
    r.free_n   = ptss_pkg::free_t'(ptss_pkg::SLOTS - used_slots);
    r.last     = last;
    return r;
  endfunction

  task automatic schedule_step(ptss_pkg::kind_e k, ptss_pkg::handle_t h,
                               ptss_pkg::interval_t p, ptss_pkg::arg_t a);
    ptss_pkg::idx_t slot;
    int             fired;
    logic           found;
    fire_report_t   tail;
    slot  = ptss_pkg::idx_t'(ptss_pkg::SLOTS);
    fired = 0;
    found = 1'b0;
    unique case (k)
      ptss_pkg::KIND_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int i = 0; i < ptss_pkg::SLOTS; i++) begin
          if (slot_handle[i] != '0 && slot_period[i] != '0 &&
              tick_count % ptss_pkg::tick_t'(slot_period[i]) == '0) begin
            due_results.push_back(make_report(1'b1, slot_handle[i], slot_arg[i],
                                              ptss_pkg::idx_t'(ptss_pkg::SLOTS), 1'b0));
            fired++;
          end
        end
        if (fired == 0) begin
          due_results.push_back(make_report(1'b0, '0, '0,
                                            ptss_pkg::idx_t'(ptss_pkg::SLOTS), 1'b1));
        end else begin
          tail = due_results.pop_back();
          tail.last = 1'b1;
          due_results.push_back(tail);
        end
      end
      ptss_pkg::KIND_ADD: begin
        if (h == '0) begin
          due_results.push_back(make_report(1'b0, '0, '0,
                                            ptss_pkg::idx_t'(ptss_pkg::SLOTS), 1'b1));
        end else begin
          for (int i = 0; i < ptss_pkg::SLOTS; i++) begin
            if (!found && slot_handle[i] == '0) begin
              slot_handle[i] = h;
              slot_period[i] = p;
              slot_arg[i]    = a;
              used_slots     = used_slots + 1'b1;
              slot           = ptss_pkg::idx_t'(i);
              found          = 1'b1;
            end
          end
          // The task fires once on its add, whether or not a slot was free.
          due_results.push_back(make_report(1'b1, h, a, slot, 1'b1));
        end
      end
      ptss_pkg::KIND_DEL: begin
        if (h != '0) begin
          for (int i = 0; i < ptss_pkg::SLOTS; i++) begin
            if (!found && slot_handle[i] == h) begin
              slot_handle[i] = '0;
              slot_period[i] = '0;
              used_slots     = used_slots - 1'b1;
              slot           = ptss_pkg::idx_t'(i);
              found          = 1'b1;
            end
          end
        end
        due_results.push_back(make_report(1'b0, '0, '0, slot, 1'b1));
      end
      default: begin
        due_results.push_back(make_report(1'b0, '0, '0,
                                          ptss_pkg::idx_t'(ptss_pkg::SLOTS), 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fire_report_t want;
    if (!rst_ni) begin
      tick_count = '0;
      used_slots = '0;
      for (int i = 0; i < ptss_pkg::SLOTS; i++) begin
        slot_handle[i] = '0;
        slot_period[i] = '0;
        slot_arg[i]    = '0;
      end
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with none expected: fire %0d, handle %0d",
                 res_i.fire, res_i.fired_handle);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("fire", 16'(want.fire), 16'(res_i.fire));
          check_field("fired_handle", want.handle, res_i.fired_handle);
          check_field("fired_argument", want.argument, res_i.fired_argument);
          check_field("slot_index", 16'(want.slot), 16'(res_i.slot_index));
          check_field("free_slots", 16'(want.free_n), 16'(res_i.free_slots));
          check_field("last", 16'(want.last), 16'(res_i.last));
        end
      end
      if (req_i.valid && req_i.ready) begin
        schedule_step(ptss_pkg::kind_e'(req_i.kind), req_i.task_handle, req_i.period,
                      req_i.task_argument);
      end
      pending_o <= due_results.size();
    end
  end

endmodule

/* bench/periodic_task_slot_scheduler_test.sv */
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_test: top of the slot scheduler testbench
// Drives directed and random tick, add, delete and unused requests with random
// gaps and result stalls, and leaves prediction to the checker beside the block.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_test;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 250;
  localparam int unsigned TailCycles  = 60;

  logic              clk_i;
  logic              rst_ni;
  logic              burst;
  int unsigned       pending;
  int unsigned       fail_count;
  int unsigned       idle_cycles;
  ptss_pkg::handle_t live_handles[$];

  ptss_in_if  req ();
  ptss_out_if res ();

  periodic_task_slot_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  slot_fire_checker fire_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .res_i        (res),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // In a burst phase neither side inserts any wait.
  function automatic int unsigned draw_wait();
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // Returns at the clock edge at which the request transaction completes.
  task automatic send_request(ptss_pkg::kind_e k, ptss_pkg::handle_t h,
                              ptss_pkg::interval_t p, ptss_pkg::arg_t a);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid         <= 1'b1;
    req.kind          <= k;
    req.task_handle   <= h;
    req.period        <= p;
    req.task_argument <= a;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic hold_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_request();
    int unsigned         pick;
    int unsigned         sel;
    int unsigned         idx;
    ptss_pkg::kind_e     k;
    ptss_pkg::handle_t   h;
    ptss_pkg::interval_t p;
    ptss_pkg::arg_t      a;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    h    = ptss_pkg::handle_t'($urandom_range(1, 65535));
    a    = ptss_pkg::arg_t'($urandom);
    // Small periods keep ticks firing often; zero and wide ones stay in the mix.
    if (sel == 0) p = '0;
    else if (sel == 1) p = ptss_pkg::interval_t'($urandom);
    else p = ptss_pkg::interval_t'($urandom_range(1, 6));
    if (pick < 48) begin
      k = ptss_pkg::KIND_TICK;
    end else if (pick < 72) begin
      k = ptss_pkg::KIND_ADD;
      if (live_handles.size() != 0 && $urandom_range(0, 4) == 0) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      end
      live_handles.push_back(h);
    end else if (pick < 94) begin
      k = ptss_pkg::KIND_DEL;
      if (live_handles.size() != 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, live_handles.size() - 1);
        h   = live_handles[idx];
        live_handles.delete(idx);
      end
    end else if (pick < 97) begin
      k = ptss_pkg::KIND_NONE;
      h = ptss_pkg::handle_t'($urandom);
    end else begin
      k = (sel < 5) ? ptss_pkg::KIND_ADD : ptss_pkg::KIND_DEL;
      h = '0;
    end
    send_request(k, h, p, a);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    req.valid         <= 1'b0;
    req.kind          <= ptss_pkg::KIND_TICK;
    req.task_handle   <= '0;
    req.period        <= '0;
    req.task_argument <= '0;
    burst = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, ignored and unmatched requests.
    send_request(ptss_pkg::KIND_TICK, '0, '0, '0);
    send_request(ptss_pkg::KIND_ADD, '0, 16'd5, 16'hFFFF);
    send_request(ptss_pkg::KIND_DEL, '0, '0, '0);
    send_request(ptss_pkg::KIND_DEL, 16'h1234, '0, '0);
    send_request(ptss_pkg::KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Fill the table, with a zero period, a duplicate handle and an overflow.
    send_request(ptss_pkg::KIND_ADD, 16'hFFFF, 16'd1, 16'hFFFF);
    send_request(ptss_pkg::KIND_ADD, 16'h0001, 16'd2, 16'h0000);
    send_request(ptss_pkg::KIND_ADD, 16'h8000, 16'd0, 16'h5A5A);
    send_request(ptss_pkg::KIND_ADD, 16'h0001, 16'hFFFF, 16'hA5A5);
    send_request(ptss_pkg::KIND_ADD, 16'h7777, 16'd3, 16'h1234);
    repeat (4) send_request(ptss_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // The first of the two matching slots goes first.
    send_request(ptss_pkg::KIND_DEL, 16'h0001, '0, '0);
    send_request(ptss_pkg::KIND_TICK, '0, '0, '0);
    send_request(ptss_pkg::KIND_ADD, 16'h0002, 16'd1, 16'h0F0F);
    send_request(ptss_pkg::KIND_TICK, '0, '0, '0);
    send_request(ptss_pkg::KIND_DEL, 16'h0001, '0, '0);
    send_request(ptss_pkg::KIND_DEL, 16'hFFFF, '0, '0);
    send_request(ptss_pkg::KIND_DEL, 16'h8000, '0, '0);
    send_request(ptss_pkg::KIND_DEL, 16'h0002, '0, '0);
    send_request(ptss_pkg::KIND_TICK, '0, '0, '0);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      burst = ((i / 30) % 3 == 2);
      if (i == RandomItems / 2) hold_until_drained();
      random_request();
    end
    burst = 1'b0;

    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS periodic_task_slot_scheduler");
    end else begin
      $display("FAIL periodic_task_slot_scheduler");
    end
    $finish;
  end

  // Result receiver: stalls for a drawn number of cycles before each transaction.
  initial begin
    int unsigned stall;
    res.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL periodic_task_slot_scheduler");
    $finish;
  end

endmodule
